@@ sv/qst_pkg.sv @@
`default_nettype none
package qst_pkg;

  localparam int SLOTS = 1024;

  localparam logic [1:0] MODE_SUBMIT  = 2'd0;
  localparam logic [1:0] MODE_SEND    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;
  localparam logic [1:0] MODE_RESP    = 2'd3;

  localparam logic [3:0] ST_ACCEPTED   = 4'd0;
  localparam logic [3:0] ST_BAD_IPS    = 4'd1;
  localparam logic [3:0] ST_NO_FREE    = 4'd2;
  localparam logic [3:0] ST_SENT       = 4'd3;
  localparam logic [3:0] ST_NONE_READY = 4'd4;
  localparam logic [3:0] ST_NONE_EXP   = 4'd5;
  localparam logic [3:0] ST_REQUEUED   = 4'd6;
  localparam logic [3:0] ST_EXHAUSTED  = 4'd7;
  localparam logic [3:0] ST_RESOLVED   = 4'd8;
  localparam logic [3:0] ST_BAD_SLOT   = 4'd9;
  localparam logic [3:0] ST_NOT_OUT    = 4'd10;
  localparam logic [3:0] ST_TYPE_MIS   = 4'd11;
  localparam logic [3:0] ST_ADDR_MIS   = 4'd12;
  localparam logic [3:0] ST_NAME_MIS   = 4'd13;

  localparam logic [1:0] LST_NONE  = 2'd0;
  localparam logic [1:0] LST_READY = 2'd1;
  localparam logic [1:0] LST_WAIT  = 2'd2;

  localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_RETRIES  = 3'd1;
  localparam logic [2:0] CFG_RTOTAL   = 3'd2;
  localparam logic [2:0] CFG_RADDR0   = 3'd3;
  localparam logic [2:0] CFG_RADDR1   = 3'd4;
  localparam logic [2:0] CFG_RADDR2   = 3'd5;
  localparam logic [2:0] CFG_RADDR3   = 3'd6;
  localparam logic [2:0] CFG_WORKER   = 3'd7;

  localparam logic [2:0] RESOLVERS = 3'd4;
  localparam logic [7:0] MAX_IPS   = 8'd16;
  localparam logic [14:0] PORT_BASE = 15'd1024;

  typedef struct packed {
    logic [3:0]  status;
    logic [9:0]  slot;
    logic [14:0] src_port;
    logic [15:0] dns_id;
    logic [31:0] resolver;
    logic [15:0] handle;
    logic [15:0] qtype;
    logic        is_retry;
    logic [1:0]  rcode_class;
  } result_t;

  function automatic logic [1:0] rcode_class(input logic [3:0] rc);
    logic [1:0] c;
    case (rc)
      4'd0:    c = 2'd0;
      4'd2:    c = 2'd1;
      4'd3:    c = 2'd2;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/qst_in_if.sv @@
`default_nettype none
interface qst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  logic [15:0] query_type;
  logic [31:0] name_tag;
  logic [15:0] request_handle;
  logic [7:0]  ip_count;
  logic [13:0] slot_index;
  logic [31:0] source_addr;
  logic [3:0]  rcode;

  modport source (output valid, mode, now_ms, query_type, name_tag, request_handle,
                  ip_count, slot_index, source_addr, rcode, input ready);
  modport sink (input valid, mode, now_ms, query_type, name_tag, request_handle,
                ip_count, slot_index, source_addr, rcode, output ready);
endinterface
`default_nettype wire

@@ sv/qst_out_if.sv @@
`default_nettype none
interface qst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [9:0]  slot;
  logic [14:0] src_port;
  logic [15:0] dns_id;
  logic [31:0] resolver_out;
  logic [15:0] handle_out;
  logic [15:0] type_out;
  logic        is_retry;
  logic [1:0]  rcode_class;

  modport source (output valid, status, slot, src_port, dns_id, resolver_out, handle_out,
                  type_out, is_retry, rcode_class, input ready);
  modport sink (input valid, status, slot, src_port, dns_id, resolver_out, handle_out,
                type_out, is_retry, rcode_class, output ready);
endinterface
`default_nettype wire

@@ sv/qst_ram.sv @@
`default_nettype none
module qst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ sv/query_slot_tracker.sv @@
// query_slot_tracker: slot bookkeeping for outstanding DNS queries.
// in_i carries one request beat (submit, send, timeout check or response);
// out_o returns exactly one result beat per request, valid/ready handshake.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write the configuration registers; write
// only while no request is in flight.
// Each request runs in two steps: the accept edge reads the slot memories
// (registered read port), the next edge writes them back and loads the
// result register. No new request is taken while this read-modify-write
// round on the slot and link memories is under way.
// The result beat turns valid when the result register is loaded.
// After reset the list-membership memory is swept to zero, one entry per
// cycle over all SLOTS entries; in_i.ready stays low during the sweep.
// Config writes are taken during the sweep. The free stack needs no sweep:
// a low-water mark tells entries never written, which read as their index.
// A stalled result holds in the output register; a new request is accepted
// once that register is empty or being drained in the same cycle.
`default_nettype none
module query_slot_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  qst_in_if.sink           in_i,
  qst_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);
  localparam int SW = $clog2(qst_pkg::SLOTS);
  localparam int CW = SW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(qst_pkg::SLOTS);

  localparam logic [1:0] FSM_CLEAR = 2'd0;
  localparam logic [1:0] FSM_IDLE  = 2'd1;
  localparam logic [1:0] FSM_EXEC  = 2'd2;

  // configuration
  logic [15:0] timeout_q;
  logic [7:0]  max_retries_q;
  logic [2:0]  rtotal_q;
  logic [31:0] raddr_q [4];
  logic [5:0]  worker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= 16'd1000;
      max_retries_q <= 8'd3;
      rtotal_q      <= 3'd1;
      raddr_q[0]    <= '0;
      raddr_q[1]    <= '0;
      raddr_q[2]    <= '0;
      raddr_q[3]    <= '0;
      worker_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qst_pkg::CFG_TIMEOUT: timeout_q     <= cfg_wdata_i[15:0];
        qst_pkg::CFG_RETRIES: max_retries_q <= cfg_wdata_i[7:0];
        qst_pkg::CFG_RTOTAL:  rtotal_q      <= cfg_wdata_i[2:0];
        qst_pkg::CFG_RADDR0:  raddr_q[0]    <= cfg_wdata_i;
        qst_pkg::CFG_RADDR1:  raddr_q[1]    <= cfg_wdata_i;
        qst_pkg::CFG_RADDR2:  raddr_q[2]    <= cfg_wdata_i;
        qst_pkg::CFG_RADDR3:  raddr_q[3]    <= cfg_wdata_i;
        qst_pkg::CFG_WORKER:  worker_q      <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] clr_q;
  logic [CW-1:0] fc_q, fc_d;
  logic [CW-1:0] lw_q, lw_d;
  logic [SW-1:0] rhead_q, rhead_d, rtail_q, rtail_d;
  logic          rne_q, rne_d;
  logic [SW-1:0] whead_q, whead_d, wtail_q, wtail_d;
  logic          wne_q, wne_d;
  logic [1:0]    rr_q, rr_d;
  logic          ovalid_q, ovalid_d;
  qst_pkg::result_t res_q, res_d;

  // latched request
  logic [1:0]  mode_q;
  logic [31:0] now_q, tag_q, src_q;
  logic [15:0] qtype_q, handle_q;
  logic [7:0]  ips_q;
  logic [13:0] sidx_q;
  logic [3:0]  rcode_q;

  logic accept;
  assign in_i.ready = (state_q == FSM_IDLE) && (!ovalid_q || out_o.ready);
  assign accept = in_i.valid && in_i.ready;

  // memories
  logic [SW-1:0] rd_addr;
  logic [63:0]   info_rd, info_wd;
  logic          info_we;
  logic [31:0]   rsv_rd, rsv_wd;
  logic          rsv_we;
  logic [7:0]    tries_rd, tries_wd;
  logic          tries_we;
  logic [31:0]   sent_rd;
  logic          sent_we;
  logic [1:0]    mbr_rd, mbr_wd, mbr_wd_x;
  logic          mbr_we, mbr_we_x;
  logic [SW-1:0] mbr_wa, s;
  logic [SW-1:0] nx_rd, nx_wa, nx_wd;
  logic          nx_we;
  logic [SW-1:0] pv_rd, pv_wa, pv_wd;
  logic          pv_we;
  logic [SW-1:0] fs_rd, fs_ra, fs_wa, fs_wd;
  logic          fs_we;

  always_comb begin
    case (in_i.mode)
      qst_pkg::MODE_SEND:    rd_addr = rhead_q;
      qst_pkg::MODE_TIMEOUT: rd_addr = whead_q;
      default:               rd_addr = in_i.slot_index[SW-1:0];
    endcase
  end
  assign fs_ra = SW'(fc_q - CW'(1));

  assign mbr_we = (state_q == FSM_CLEAR) || mbr_we_x;
  assign mbr_wa = (state_q == FSM_CLEAR) ? clr_q[SW-1:0] : s;
  assign mbr_wd = (state_q == FSM_CLEAR) ? qst_pkg::LST_NONE : mbr_wd_x;

  qst_ram #(.WIDTH(64), .DEPTH(qst_pkg::SLOTS)) u_info (.clk_i, .we_i(info_we), .waddr_i(s),
    .wdata_i(info_wd), .re_i(accept), .raddr_i(rd_addr), .rdata_o(info_rd));
  qst_ram #(.WIDTH(32), .DEPTH(qst_pkg::SLOTS)) u_rsv (.clk_i, .we_i(rsv_we), .waddr_i(s),
    .wdata_i(rsv_wd), .re_i(accept), .raddr_i(rd_addr), .rdata_o(rsv_rd));
  qst_ram #(.WIDTH(8), .DEPTH(qst_pkg::SLOTS)) u_tries (.clk_i, .we_i(tries_we), .waddr_i(s),
    .wdata_i(tries_wd), .re_i(accept), .raddr_i(rd_addr), .rdata_o(tries_rd));
  qst_ram #(.WIDTH(32), .DEPTH(qst_pkg::SLOTS)) u_sent (.clk_i, .we_i(sent_we), .waddr_i(s),
    .wdata_i(now_q), .re_i(accept), .raddr_i(rd_addr), .rdata_o(sent_rd));
  qst_ram #(.WIDTH(2), .DEPTH(qst_pkg::SLOTS)) u_mbr (.clk_i, .we_i(mbr_we), .waddr_i(mbr_wa),
    .wdata_i(mbr_wd), .re_i(accept), .raddr_i(rd_addr), .rdata_o(mbr_rd));
  qst_ram #(.WIDTH(SW), .DEPTH(qst_pkg::SLOTS)) u_nx (.clk_i, .we_i(nx_we), .waddr_i(nx_wa),
    .wdata_i(nx_wd), .re_i(accept), .raddr_i(rd_addr), .rdata_o(nx_rd));
  qst_ram #(.WIDTH(SW), .DEPTH(qst_pkg::SLOTS)) u_pv (.clk_i, .we_i(pv_we), .waddr_i(pv_wa),
    .wdata_i(pv_wd), .re_i(accept), .raddr_i(rd_addr), .rdata_o(pv_rd));
  qst_ram #(.WIDTH(SW), .DEPTH(qst_pkg::SLOTS)) u_fs (.clk_i, .we_i(fs_we), .waddr_i(fs_wa),
    .wdata_i(fs_wd), .re_i(accept), .raddr_i(fs_ra), .rdata_o(fs_rd));

  function automatic logic [1:0] rr_next(input logic [1:0] rr, input logic [2:0] tot);
    logic [2:0] t;
    logic [2:0] v;
    t = tot;
    if (t == 3'd0) t = 3'd1;
    if (t > qst_pkg::RESOLVERS) t = qst_pkg::RESOLVERS;
    v = 3'(rr) + 3'd1;
    for (int k = 0; k < 4; k++) begin
      if (v >= t) v = v - t;
    end
    return v[1:0];
  endfunction

  // execute: data from the accept-edge read is on the RAM outputs now
  always_comb begin
    logic [CW-1:0] fcm1;
    logic          first, last, do_unlink, do_release, push_rdy, push_wt;
    logic [8:0]    tp1;
    logic [1:0]    rrn;
    logic [31:0]   elapsed;

    state_d  = state_q;
    fc_d     = fc_q;
    lw_d     = lw_q;
    rhead_d  = rhead_q; rtail_d = rtail_q; rne_d = rne_q;
    whead_d  = whead_q; wtail_d = wtail_q; wne_d = wne_q;
    rr_d     = rr_q;
    ovalid_d = ovalid_q && !out_o.ready;
    res_d    = res_q;
    info_we  = 1'b0; info_wd = {handle_q, tag_q, qtype_q};
    rsv_we   = 1'b0; rsv_wd = '0;
    tries_we = 1'b0; tries_wd = '0;
    sent_we  = 1'b0;
    mbr_we_x = 1'b0; mbr_wd_x = qst_pkg::LST_NONE;
    nx_we    = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we    = 1'b0; pv_wa = '0; pv_wd = '0;
    fs_we    = 1'b0; fs_wa = fc_q[SW-1:0]; fs_wd = '0;
    fcm1       = fc_q - CW'(1);
    do_unlink  = 1'b0;
    do_release = 1'b0;
    push_rdy   = 1'b0;
    push_wt    = 1'b0;
    tp1        = 9'(tries_rd) + 9'd1;
    rrn        = rr_next(rr_q, rtotal_q);
    elapsed    = now_q - sent_rd;
    s          = sidx_q[SW-1:0];

    case (mode_q)
      qst_pkg::MODE_SUBMIT: s = (fcm1 < lw_q) ? fcm1[SW-1:0] : fs_rd;
      qst_pkg::MODE_SEND:   s = rhead_q;
      qst_pkg::MODE_TIMEOUT: s = whead_q;
      default: ;
    endcase
    first = (mbr_rd == qst_pkg::LST_READY) ? (rhead_q == s) : (whead_q == s);
    last  = (mbr_rd == qst_pkg::LST_READY) ? (rtail_q == s) : (wtail_q == s);

    if (state_q == FSM_CLEAR) begin
      if (clr_q == SLOTS_C - CW'(1)) state_d = FSM_IDLE;
    end else if (accept) begin
      state_d = FSM_EXEC;
    end else if (state_q == FSM_EXEC) begin
      state_d  = FSM_IDLE;
      ovalid_d = 1'b1;
      res_d    = '0;
      case (mode_q)
        qst_pkg::MODE_SUBMIT: begin
          if (fc_q == '0) begin
            res_d.status = qst_pkg::ST_NO_FREE;
          end else if (ips_q == 8'd0 || ips_q > qst_pkg::MAX_IPS) begin
            res_d.status = qst_pkg::ST_BAD_IPS;
          end else begin
            fc_d = fcm1;
            if (fcm1 < lw_q) lw_d = fcm1;
            info_we  = 1'b1;
            tries_we = 1'b1;
            mbr_we_x = 1'b1; mbr_wd_x = qst_pkg::LST_READY;
            push_rdy = 1'b1;
            res_d.status = qst_pkg::ST_ACCEPTED;
            res_d.slot   = 10'(s);
            res_d.handle = handle_q;
            res_d.qtype  = qtype_q;
          end
        end
        qst_pkg::MODE_SEND: begin
          if (!rne_q) begin
            res_d.status = qst_pkg::ST_NONE_READY;
          end else begin
            rr_d    = rrn;
            rsv_we  = 1'b1; rsv_wd = raddr_q[rrn];
            sent_we = 1'b1;
            do_unlink = 1'b1;
            push_wt   = 1'b1;
            mbr_we_x  = 1'b1; mbr_wd_x = qst_pkg::LST_WAIT;
            res_d.status   = qst_pkg::ST_SENT;
            res_d.slot     = 10'(s);
            res_d.src_port = 15'(s) + qst_pkg::PORT_BASE;
            res_d.dns_id   = {6'(worker_q + 6'd1), 10'd0};
            res_d.resolver = raddr_q[rrn];
            res_d.handle   = info_rd[63:48];
            res_d.qtype    = info_rd[15:0];
            res_d.is_retry = (tries_rd != 8'd0);
          end
        end
        qst_pkg::MODE_TIMEOUT: begin
          if (!wne_q || elapsed < {16'd0, timeout_q}) begin
            res_d.status = qst_pkg::ST_NONE_EXP;
          end else begin
            res_d.slot   = 10'(s);
            res_d.handle = info_rd[63:48];
            res_d.qtype  = info_rd[15:0];
            do_unlink    = 1'b1;
            if (tp1 > {1'b0, max_retries_q}) begin
              do_release   = 1'b1;
              res_d.status = qst_pkg::ST_EXHAUSTED;
            end else begin
              tries_we = 1'b1;
              tries_wd = (tp1 > 9'd255) ? 8'd255 : tp1[7:0];
              mbr_we_x = 1'b1; mbr_wd_x = qst_pkg::LST_READY;
              push_rdy = 1'b1;
              res_d.status = qst_pkg::ST_REQUEUED;
            end
          end
        end
        default: begin
          res_d.rcode_class = qst_pkg::rcode_class(rcode_q);
          if ({1'b0, sidx_q} >= 15'(qst_pkg::SLOTS)) begin
            res_d.status = qst_pkg::ST_BAD_SLOT;
          end else begin
            res_d.slot = 10'(s);
            if (mbr_rd == qst_pkg::LST_NONE) begin
              res_d.status = qst_pkg::ST_NOT_OUT;
            end else if (info_rd[15:0] != qtype_q) begin
              res_d.status = qst_pkg::ST_TYPE_MIS;
            end else if (rsv_rd != src_q) begin
              res_d.status = qst_pkg::ST_ADDR_MIS;
            end else if (info_rd[47:16] != tag_q) begin
              res_d.status = qst_pkg::ST_NAME_MIS;
            end else begin
              res_d.status = qst_pkg::ST_RESOLVED;
              res_d.handle = info_rd[63:48];
              res_d.qtype  = info_rd[15:0];
              do_unlink    = 1'b1;
              do_release   = 1'b1;
            end
          end
        end
      endcase

      if (do_unlink) begin
        if (first && last) begin
          if (mbr_rd == qst_pkg::LST_READY) rne_d = 1'b0; else wne_d = 1'b0;
        end else if (first) begin
          if (mbr_rd == qst_pkg::LST_READY) rhead_d = nx_rd; else whead_d = nx_rd;
        end else if (last) begin
          if (mbr_rd == qst_pkg::LST_READY) rtail_d = pv_rd; else wtail_d = pv_rd;
        end else begin
          nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
          pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
        end
      end

      if (do_release) begin
        mbr_we_x = 1'b1; mbr_wd_x = qst_pkg::LST_NONE;
        tries_we = 1'b1; tries_wd = '0;
        if (fc_q < SLOTS_C) begin
          fs_we = 1'b1; fs_wd = s;
          fc_d  = fc_q + CW'(1);
        end
      end

      // pushed slot never hits the unlinked list, so ends updated above stay valid
      if (push_rdy) begin
        if (rne_d) begin
          nx_we = 1'b1; nx_wa = rtail_d; nx_wd = s;
          pv_we = 1'b1; pv_wa = s;       pv_wd = rtail_d;
        end else begin
          rhead_d = s;
        end
        rtail_d = s;
        rne_d   = 1'b1;
      end
      if (push_wt) begin
        if (wne_d) begin
          nx_we = 1'b1; nx_wa = wtail_d; nx_wd = s;
          pv_we = 1'b1; pv_wa = s;       pv_wd = wtail_d;
        end else begin
          whead_d = s;
        end
        wtail_d = s;
        wne_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_CLEAR;
      clr_q    <= '0;
      fc_q     <= SLOTS_C;
      lw_q     <= SLOTS_C;
      rhead_q  <= '0; rtail_q <= '0; rne_q <= 1'b0;
      whead_q  <= '0; wtail_q <= '0; wne_q <= 1'b0;
      rr_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (state_q == FSM_CLEAR) clr_q <= clr_q + CW'(1);
      fc_q     <= fc_d;
      lw_q     <= lw_d;
      rhead_q  <= rhead_d; rtail_q <= rtail_d; rne_q <= rne_d;
      whead_q  <= whead_d; wtail_q <= wtail_d; wne_q <= wne_d;
      rr_q     <= rr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      mode_q   <= in_i.mode;
      now_q    <= in_i.now_ms;
      qtype_q  <= in_i.query_type;
      tag_q    <= in_i.name_tag;
      handle_q <= in_i.request_handle;
      ips_q    <= in_i.ip_count;
      sidx_q   <= in_i.slot_index;
      src_q    <= in_i.source_addr;
      rcode_q  <= in_i.rcode;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.status       = res_q.status;
  assign out_o.slot         = res_q.slot;
  assign out_o.src_port     = res_q.src_port;
  assign out_o.dns_id       = res_q.dns_id;
  assign out_o.resolver_out = res_q.resolver;
  assign out_o.handle_out   = res_q.handle;
  assign out_o.type_out     = res_q.qtype;
  assign out_o.is_retry     = res_q.is_retry;
  assign out_o.rcode_class  = res_q.rcode_class;

`ifndef SYNTH
  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= SLOTS_C) else $error("free count above slot total");
  a_lowwater: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_q <= fc_q) else $error("free stack low-water mark above free count");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 ovalid_q) else $error("request produced no result beat");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_query_slot_tracker.sv @@
`timescale 1ns / 1ps
module tb_query_slot_tracker;

  localparam int NSLOT = qst_pkg::SLOTS;
  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PER_PHASE = 130;
  localparam int NPHASE = 7;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] now;
    logic [15:0] qtype;
    logic [31:0] tag;
    logic [15:0] handle;
    logic [7:0]  ips;
    logic [13:0] sidx;
    logic [31:0] src;
    logic [3:0]  rcode;
  } req_t;

  typedef enum int {
    RSP_GOOD_WAIT, RSP_GOOD_READY, RSP_BAD_TYPE, RSP_BAD_ADDR, RSP_BAD_NAME,
    RSP_IDLE_SLOT, RSP_OUT_RANGE
  } rsp_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  qst_in_if  in_if ();
  qst_out_if out_if ();

  query_slot_tracker u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_if), .out_o(out_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always #1 clk = ~clk;

  // tracker shadow state
  bit          busy [NSLOT];
  bit          sent_once [NSLOT];
  logic [15:0] s_handle [NSLOT];
  logic [31:0] s_tag [NSLOT];
  logic [15:0] s_type [NSLOT];
  logic [31:0] s_res [NSLOT];
  logic [7:0]  s_tries [NSLOT];
  logic [31:0] s_sent [NSLOT];
  logic [1:0]  member [NSLOT];
  int          free_stk [NSLOT];
  int          free_top;
  int          ready_list [$];
  int          wait_list [$];
  int          rr_ptr;

  logic [15:0] c_tmo;
  logic [7:0]  c_retries;
  logic [2:0]  c_total;
  logic [31:0] c_addr [4];
  logic [5:0]  c_worker;

  req_t    pend_q [$];
  qst_pkg::result_t result_q [$];
  logic [31:0] cur_ms;

  int send_idle, recv_idle;
  bit hold_go;
  int hold_left = HOLD_CYCLES;
  logic in_fire;
  int quiet, fails, beats;
  bit [15:0] st_seen;

  function automatic void drop_slot(ref int q[$], input int s);
    foreach (q[i]) if (q[i] == s) begin
      q.delete(i);
      return;
    end
  endfunction

  function automatic void unlist(int s);
    if (member[s] == qst_pkg::LST_READY) drop_slot(ready_list, s);
    else if (member[s] == qst_pkg::LST_WAIT) drop_slot(wait_list, s);
    member[s] = qst_pkg::LST_NONE;
  endfunction

  function automatic void free_slot(int s);
    unlist(s);
    busy[s] = 0;
    s_tries[s] = '0;
    if (free_top < NSLOT) begin
      free_stk[free_top] = s;
      free_top++;
    end
  endfunction

  function automatic qst_pkg::result_t track_step(req_t q);
    qst_pkg::result_t r;
    int s, tot, tr;
    logic [31:0] wide;
    r = '0;
    case (q.mode)
      qst_pkg::MODE_SUBMIT: begin
        if (free_top == 0) r.status = qst_pkg::ST_NO_FREE;
        else if (q.ips == 0 || q.ips > qst_pkg::MAX_IPS) r.status = qst_pkg::ST_BAD_IPS;
        else begin
          free_top--;
          s = free_stk[free_top];
          s_handle[s] = q.handle; s_tag[s] = q.tag; s_type[s] = q.qtype;
          s_tries[s] = '0; busy[s] = 1;
          unlist(s);
          ready_list.insert(ready_list.size(), s);
          member[s] = qst_pkg::LST_READY;
          r.status = qst_pkg::ST_ACCEPTED; r.slot = 10'(s);
          r.handle = q.handle; r.qtype = q.qtype;
        end
      end
      qst_pkg::MODE_SEND: begin
        if (ready_list.size() == 0) r.status = qst_pkg::ST_NONE_READY;
        else begin
          s = ready_list[0];
          tot = c_total;
          if (tot < 1) tot = 1;
          if (tot > qst_pkg::RESOLVERS) tot = qst_pkg::RESOLVERS;
          rr_ptr = (rr_ptr + 1) % tot;
          s_res[s] = c_addr[rr_ptr];
          s_sent[s] = q.now;
          sent_once[s] = 1;
          unlist(s);
          wait_list.insert(wait_list.size(), s);
          member[s] = qst_pkg::LST_WAIT;
          wide = (32'(c_worker) + 1) << 10;
          r.status = qst_pkg::ST_SENT; r.slot = 10'(s);
          r.src_port = 15'(s) + qst_pkg::PORT_BASE;
          r.dns_id = wide[15:0];
          r.resolver = s_res[s];
          r.handle = s_handle[s]; r.qtype = s_type[s];
          r.is_retry = s_tries[s] != 0;
        end
      end
      qst_pkg::MODE_TIMEOUT: begin
        if (wait_list.size() == 0) r.status = qst_pkg::ST_NONE_EXP;
        else begin
          s = wait_list[0];
          wide = q.now - s_sent[s];
          if (wide < {16'd0, c_tmo}) r.status = qst_pkg::ST_NONE_EXP;
          else begin
            tr = int'(s_tries[s]) + 1;
            r.slot = 10'(s); r.handle = s_handle[s]; r.qtype = s_type[s];
            if (tr > int'(c_retries)) begin
              free_slot(s);
              r.status = qst_pkg::ST_EXHAUSTED;
            end else begin
              s_tries[s] = tr > 255 ? 8'd255 : 8'(tr);
              unlist(s);
              ready_list.insert(ready_list.size(), s);
              member[s] = qst_pkg::LST_READY;
              r.status = qst_pkg::ST_REQUEUED;
            end
          end
        end
      end
      default: begin
        case (q.rcode)
          4'd0: r.rcode_class = 2'd0;
          4'd2: r.rcode_class = 2'd1;
          4'd3: r.rcode_class = 2'd2;
          default: r.rcode_class = 2'd3;
        endcase
        if (q.sidx >= NSLOT) r.status = qst_pkg::ST_BAD_SLOT;
        else begin
          s = q.sidx;
          r.slot = 10'(s);
          if (!busy[s]) r.status = qst_pkg::ST_NOT_OUT;
          else if (s_type[s] != q.qtype) r.status = qst_pkg::ST_TYPE_MIS;
          else if (s_res[s] != q.src) r.status = qst_pkg::ST_ADDR_MIS;
          else if (s_tag[s] != q.tag) r.status = qst_pkg::ST_NAME_MIS;
          else begin
            r.status = qst_pkg::ST_RESOLVED; r.handle = s_handle[s]; r.qtype = s_type[s];
            free_slot(s);
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic req_t rand_req(logic [1:0] mode);
    req_t q;
    q.mode = mode; q.now = cur_ms;
    q.qtype = 16'($urandom); q.tag = $urandom; q.handle = 16'($urandom);
    q.ips = 8'($urandom_range(1, qst_pkg::MAX_IPS)); q.sidx = 14'($urandom);
    q.src = $urandom; q.rcode = 4'($urandom);
    return q;
  endfunction

  // slot that has been sent at least once and is still outstanding
  function automatic int pick_sent(bit from_ready);
    int cand [$];
    if (!from_ready && wait_list.size() > 0)
      return wait_list[$urandom_range(wait_list.size() - 1)];
    foreach (ready_list[i])
      if (sent_once[ready_list[i]]) cand.insert(cand.size(), ready_list[i]);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  function automatic req_t mk_resp(rsp_kind_e kind);
    req_t q;
    int s, n;
    q = rand_req(qst_pkg::MODE_RESP);
    s = -1;
    if (kind != RSP_IDLE_SLOT && kind != RSP_OUT_RANGE)
      s = pick_sent(kind == RSP_GOOD_READY || (kind != RSP_GOOD_WAIT && $urandom_range(3) == 0));
    if (s >= 0) begin
      q.sidx = 14'(s); q.qtype = s_type[s]; q.src = s_res[s]; q.tag = s_tag[s];
      if (kind == RSP_BAD_TYPE) q.qtype ^= 16'($urandom_range(1, 65535));
      if (kind == RSP_BAD_ADDR) q.src ^= $urandom_range(1, 32'hFFFF_FFFF);
      if (kind == RSP_BAD_NAME) q.tag ^= $urandom_range(1, 32'hFFFF_FFFF);
    end else if (kind == RSP_OUT_RANGE) begin
      q.sidx = 14'($urandom_range(NSLOT, 16383));
    end else begin
      // never answer a slot whose resolver was never assigned
      q.sidx = 14'($urandom_range(NSLOT - 1));
      n = 0;
      while (busy[q.sidx] && !sent_once[q.sidx] && n < 30) begin
        q.sidx = 14'($urandom_range(NSLOT - 1));
        n++;
      end
      if (busy[q.sidx] && !sent_once[q.sidx]) q.sidx = 14'($urandom_range(NSLOT, 16383));
    end
    return q;
  endfunction

  task automatic emit(req_t q);
    q.now = cur_ms;
    result_q.insert(result_q.size(), track_step(q));
    pend_q.insert(pend_q.size(), q);
  endtask

  task automatic advance_ms();
    int r;
    r = $urandom_range(99);
    if (r < 70) cur_ms += $urandom_range(0, c_tmo / 8 + 1);
    else if (r < 95) cur_ms += $urandom_range(0, c_tmo + 2);
    else cur_ms += $urandom;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    case (idx)
      qst_pkg::CFG_TIMEOUT: c_tmo = val[15:0];
      qst_pkg::CFG_RETRIES: c_retries = val[7:0];
      qst_pkg::CFG_RTOTAL:  c_total = val[2:0];
      qst_pkg::CFG_WORKER:  c_worker = val[5:0];
      default:              c_addr[idx - qst_pkg::CFG_RADDR0] = val;
    endcase
  endtask

  task automatic random_item();
    int r, k;
    req_t q;
    advance_ms();
    r = $urandom_range(99);
    if (r < 30) begin
      q = rand_req(qst_pkg::MODE_SUBMIT);
      k = $urandom_range(99);
      if (k < 5) q.ips = '0;
      else if (k < 15) q.ips = 8'($urandom_range(qst_pkg::MAX_IPS + 1, 255));
      emit(q);
    end else if (r < 55) emit(rand_req(qst_pkg::MODE_SEND));
    else if (r < 75) emit(rand_req(qst_pkg::MODE_TIMEOUT));
    else begin
      k = $urandom_range(99);
      if (k < 50) emit(mk_resp(RSP_GOOD_WAIT));
      else if (k < 58) emit(mk_resp(RSP_GOOD_READY));
      else if (k < 68) emit(mk_resp(RSP_BAD_TYPE));
      else if (k < 78) emit(mk_resp(RSP_BAD_ADDR));
      else if (k < 88) emit(mk_resp(RSP_BAD_NAME));
      else if (k < 95) emit(mk_resp(RSP_IDLE_SLOT));
      else emit(mk_resp(RSP_OUT_RANGE));
    end
  endtask

  task automatic directed_items();
    req_t q;
    emit(rand_req(qst_pkg::MODE_SEND));
    emit(rand_req(qst_pkg::MODE_TIMEOUT));
    emit(mk_resp(RSP_OUT_RANGE));
    emit(mk_resp(RSP_IDLE_SLOT));
    q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = 8'd0;   emit(q);
    q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = 8'd17;  emit(q);
    q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = 8'd255; emit(q);
    q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = 8'd1;
    q.handle = '1; q.qtype = '1; q.tag = '1; emit(q);
    q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = qst_pkg::MAX_IPS;
    q.handle = '0; q.qtype = '0; q.tag = '0; emit(q);
    q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = 8'd3; emit(q);
    repeat (3) emit(rand_req(qst_pkg::MODE_SEND));
    emit(rand_req(qst_pkg::MODE_TIMEOUT));
    emit(mk_resp(RSP_BAD_TYPE));
    emit(mk_resp(RSP_BAD_ADDR));
    emit(mk_resp(RSP_BAD_NAME));
    emit(mk_resp(RSP_GOOD_WAIT));
    cur_ms += 32'(c_tmo) + 10;
    emit(rand_req(qst_pkg::MODE_TIMEOUT));
    emit(mk_resp(RSP_GOOD_READY));
    emit(rand_req(qst_pkg::MODE_TIMEOUT));
    emit(rand_req(qst_pkg::MODE_SEND));
    emit(rand_req(qst_pkg::MODE_SEND));
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin : drv
    req_t q;
    if (rst_n && (!in_if.valid || in_fire)) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        q = pend_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.mode <= q.mode; in_if.now_ms <= q.now; in_if.query_type <= q.qtype;
        in_if.name_tag <= q.tag; in_if.request_handle <= q.handle;
        in_if.ip_count <= q.ips; in_if.slot_index <= q.sidx;
        in_if.source_addr <= q.src; in_if.rcode <= q.rcode;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_go && hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_idle;
    end
  end

  always @(posedge clk) begin : mon
    qst_pkg::result_t got, want;
    in_fire <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.status, out_if.slot, out_if.src_port, out_if.dns_id,
                out_if.resolver_out, out_if.handle_out, out_if.type_out,
                out_if.is_retry, out_if.rcode_class};
        beats++;
        st_seen[got.status] = 1'b1;
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat: %p", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch beat %0d\n  exp st=%0d slot=%0d port=%0d id=%h res=%h hdl=%h typ=%h rt=%b rc=%0d\n  got st=%0d slot=%0d port=%0d id=%h res=%h hdl=%h typ=%h rt=%b rc=%0d",
                beats, want.status, want.slot, want.src_port, want.dns_id, want.resolver,
                want.handle, want.qtype, want.is_retry, want.rcode_class,
                got.status, got.slot, got.src_port, got.dns_id, got.resolver,
                got.handle, got.qtype, got.is_retry, got.rcode_class);
          end
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stim
    logic [15:0] tmo_set [NPHASE] = '{16'd50, 16'd1, 16'd65535, 16'd0, 16'd200, 16'd20, 16'd100};
    logic [7:0]  ret_set [NPHASE] = '{8'd2, 8'd0, 8'd254, 8'd1, 8'd3, 8'd5, 8'd3};
    logic [2:0]  tot_set [NPHASE] = '{3'd3, 3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd4};
    logic [5:0]  wk_set  [NPHASE] = '{6'd63, 6'd0, 6'd62, 6'd5, 6'd17, 6'd40, 6'd1};
    req_t q;
    in_if.valid = 1'b0; in_if.mode = '0; in_if.now_ms = '0; in_if.query_type = '0;
    in_if.name_tag = '0; in_if.request_handle = '0; in_if.ip_count = '0;
    in_if.slot_index = '0; in_if.source_addr = '0; in_if.rcode = '0;
    out_if.ready = 1'b0;
    in_fire = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      free_stk[i] = i; busy[i] = 0; sent_once[i] = 0; member[i] = qst_pkg::LST_NONE;
      s_tries[i] = '0; s_res[i] = '0;
    end
    free_top = NSLOT; rr_ptr = 0;
    c_tmo = 16'd1000; c_retries = 8'd3; c_total = 3'd1; c_worker = '0;
    foreach (c_addr[i]) c_addr[i] = '0;
    cur_ms = 32'hFFFF_FFC0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    for (int p = 0; p < NPHASE; p++) begin
      drain();
      send_idle = p < 2 ? 24 : p < 4 ? 46 : 0;
      recv_idle = p < 2 ? 46 : p < 4 ? 24 : 0;
      cfg_write(qst_pkg::CFG_TIMEOUT, {16'd0, tmo_set[p]});
      cfg_write(qst_pkg::CFG_RETRIES, {24'd0, ret_set[p]});
      cfg_write(qst_pkg::CFG_RTOTAL, {29'd0, tot_set[p]});
      cfg_write(qst_pkg::CFG_RADDR0, p == 0 ? 32'hFFFF_FFFF : $urandom);
      cfg_write(qst_pkg::CFG_RADDR1, p == 0 ? 32'h0 : $urandom);
      cfg_write(qst_pkg::CFG_RADDR2, $urandom);
      cfg_write(qst_pkg::CFG_RADDR3, $urandom);
      cfg_write(qst_pkg::CFG_WORKER, {26'd0, wk_set[p]});
      @(negedge clk) cfg_we <= 1'b0;
      if (p == 0) begin
        directed_items();
        hold_go = 1'b1;
      end
      if (p < NPHASE - 1) begin
        repeat (RAND_PER_PHASE) random_item();
      end else begin
        // run the table dry, then probe the full case
        while (free_top > 0) begin
          q = rand_req(qst_pkg::MODE_SUBMIT);
          emit(q);
        end
        q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = '0; emit(q);
        q = rand_req(qst_pkg::MODE_SUBMIT); q.ips = 8'd200; emit(q);
        repeat (4) random_item();
      end
    end
    drain();
    repeat (10) @(posedge clk);
    $display("%0d result beats checked over %0d register settings; %0d of 14 status codes seen",
             beats, NPHASE, $countones(st_seen));
    $display("slot table filled to capacity once; one long output stall applied");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fails);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ query_slot_tracker.f @@
sv/qst_pkg.sv
sv/qst_in_if.sv
sv/qst_out_if.sv
sv/qst_ram.sv
sv/query_slot_tracker.sv
tb/sv/tb_query_slot_tracker.sv
